// File: src/assert_macros.svh
// Assertion shorthands used by the RTL of the mipmap downsampler.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/gcmd_pkg.sv
// Shared constants, types and the gamma table of the mipmap downsampler.
// The table is built at elaboration from exact integer arithmetic; no dependencies.
package gcmd_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int MAX_HEIGHT_DEFAULT = 2048;

  localparam int CFG_W   = 12;
  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;
  localparam int NUM_CH  = 3;
  localparam int NUM_PIX = 4;

  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET = 12'd16;

  // Depth of the result queue; a power of two so the pointers wrap by themselves.
  localparam int RESULT_FIFO_DEPTH = 16;

  localparam int SEARCH_STEPS = 8;

  typedef logic [24:0] gamma_t;
  typedef logic [26:0] gsum_t;
  typedef logic [255:0][24:0] gamma_tab_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } result_t;

  typedef struct packed {
    logic [7:0]         alpha;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } meta_t;

  // True when t - 1/2 <= 2^24 * (c/255)^2.2, checked as
  // (2t-1)^5 * 255^11 <= (2^25)^5 * c^11.
  function automatic logic gamma_ok(input int unsigned c, input int unsigned t);
    logic [255:0] a;
    logic [255:0] b;
    if (t == 0) return 1'b1;
    a = 256'd1;
    b = 256'd1;
    for (int i = 0; i < 5; i++) begin
      a = a * 256'(2 * t - 1);
      b = b << 25;
    end
    for (int i = 0; i < 11; i++) begin
      a = a * 256'd255;
      b = b * 256'(c);
    end
    return (a <= b);
  endfunction

  // Round-half-up table of (c/255)^2.2 with 24 fraction bits, found by bisection.
  function automatic gamma_tab_t gamma_table();
    gamma_tab_t  tab;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned c;
    for (int hi4 = 0; hi4 < 16; hi4++) begin
      for (int lo4 = 0; lo4 < 16; lo4++) begin
        c  = 32'(hi4 * 16 + lo4);
        lo = 0;
        hi = 32'd1 << 24;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (gamma_ok(c, mid)) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        tab[c[7:0]] = lo[24:0];
      end
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = gamma_table();

  // One bit of the output code search: keep the candidate bit when four times
  // its table entry still fits under the channel sum.
  function automatic logic [7:0] search_step(input logic [7:0] code, input gsum_t sum,
                                             input int step);
    logic [7:0] cand;
    cand = code | (8'h80 >> step);
    if ({GAMMA_TAB[cand], 2'b00} <= sum) return cand;
    return code;
  endfunction

endpackage

// File: src/gamma_correct_mipmap_downsampler.sv
// Top level of the gamma-correct 2x2 mipmap downsampler: line store, blend pipeline
// and result queue. Depends on gcmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

// The block takes source pixels (ARGB, alpha in bits 31..24) of one mip level in
// raster order and returns the pixels of the next smaller level, each with its
// column and row. Pixels of even rows are written in pairs into a single-port line
// store; on an odd row every odd column reads back the pair above it and closes a
// 2x2 block. Alpha is the truncated mean of the four alphas. Each color channel is
// averaged in linear light: the four codes go through a 256-entry gamma table, the
// entries are summed, and an eight-step pipelined bisection over the same table finds
// the greatest code whose entry, times four, does not exceed the sum. A word with
// start_image set is placed at row 0, column 0; a write of source_width also
// restarts there. The width is forced even, at least 2 and at most MAX_WIDTH; an odd
// trailing row never completes a block, and the row counter wraps at MAX_HEIGHT.
// The block accepts one pixel word per clock while pixel_stall is low. A result
// reaches the queue after the pixel that closes its block is accepted, through the
// memory read, the table and sum stages and the eight search stages. Results
// wait in a 16-word queue; the input stalls only while 16 results are accepted but
// not yet taken on the output side. There is no clearing pass after reset: the line
// store is always written in an image before it is read.
module gamma_correct_mipmap_downsampler #(
  parameter int MAX_WIDTH  = gcmd_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = gcmd_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [gcmd_pkg::CFG_W-1:0]    cfg_write_data,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [gcmd_pkg::PIX_W-1:0]    in_pixel,
  input  logic                          start_image,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [gcmd_pkg::PIX_W-1:0]    out_pixel,
  output logic [gcmd_pkg::COORD_W-1:0]  out_x,
  output logic [gcmd_pkg::COORD_W-1:0]  out_y
);
  import gcmd_pkg::*;

  localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MEM_DEPTH = MAX_WIDTH / 2;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int FIFO_AW   = $clog2(RESULT_FIFO_DEPTH);
  localparam int CNT_W     = $clog2(RESULT_FIFO_DEPTH + 1);

  // Last column index of a row for a given register value.
  function automatic logic [COL_W-1:0] last_column(input logic [CFG_W-1:0] sw);
    logic [31:0] w;
    w = {20'd0, sw[CFG_W-1:1], 1'b0};
    if (w > 32'(MAX_WIDTH)) w = 32'(MAX_WIDTH) & ~32'd1;
    if (w < 32'd2) w = 32'd2;
    return COL_W'(w - 32'd1);
  endfunction

  // Position counters and the previous pixel of the row.
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] last_col;
  logic [PIX_W-1:0] left_pixel;

  logic             accept;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             produce;

  assign accept  = pixel_valid && !pixel_stall;
  assign col_cur = start_image ? '0 : col_cnt;
  assign row_cur = start_image ? '0 : row_cnt;
  assign produce = row_cur[0] && col_cur[0];

  always_comb begin
    col_next = col_cur + COL_W'(1);
    row_next = row_cur;
    if (col_cur == last_col) begin
      col_next = '0;
      if (row_cur == ROW_W'(MAX_HEIGHT - 1)) begin
        row_next = '0;
      end else begin
        row_next = row_cur + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      last_col   <= last_column(SOURCE_WIDTH_RESET);
      left_pixel <= '0;
    end else if (cfg_write_en) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      last_col <= last_column(cfg_write_data);
    end else if (accept) begin
      col_cnt    <= col_next;
      row_cnt    <= row_next;
      left_pixel <= in_pixel;
    end
  end

  // Line store: one word holds a column pair of the last even row, the left
  // pixel in the upper half. Written at odd columns of even rows, read at odd
  // columns of odd rows, so one port serves both.
  logic [2*PIX_W-1:0] line_mem [MEM_DEPTH];
  logic [2*PIX_W-1:0] ram_q;
  logic [MEM_AW-1:0]  mem_addr;
  logic               mem_we;
  logic               mem_re;

  assign mem_addr = MEM_AW'(col_cur >> 1);
  assign mem_we   = accept && !row_cur[0] && col_cur[0];
  assign mem_re   = accept && produce;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_addr] <= {left_pixel, in_pixel};
    end
    if (mem_re) begin
      ram_q <= line_mem[mem_addr];
    end
  end

  // Stage 1: lower two pixels and the output position, aligned with ram_q.
  logic               st1_valid;
  logic [PIX_W-1:0]   st1_left;
  logic [PIX_W-1:0]   st1_pixel;
  logic [COORD_W-1:0] st1_x;
  logic [COORD_W-1:0] st1_y;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      st1_left  <= left_pixel;
      st1_pixel <= in_pixel;
      st1_x     <= COORD_W'(col_cur >> 1);
      st1_y     <= COORD_W'(row_cur >> 1);
    end
  end

  // Stage 2: gamma table lookups and the alpha mean.
  logic             st2_valid;
  gamma_t           st2_t [NUM_PIX][NUM_CH];
  meta_t            st2_meta;
  logic [PIX_W-1:0] blk_pix [NUM_PIX];
  logic [9:0]       alpha_sum;

  always_comb begin
    blk_pix[0] = ram_q[2*PIX_W-1:PIX_W];
    blk_pix[1] = ram_q[PIX_W-1:0];
    blk_pix[2] = st1_left;
    blk_pix[3] = st1_pixel;
    alpha_sum  = 10'(blk_pix[0][31:24]) + 10'(blk_pix[1][31:24])
               + 10'(blk_pix[2][31:24]) + 10'(blk_pix[3][31:24]);
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PIX; p++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        st2_t[p][ch] <= GAMMA_TAB[blk_pix[p][8*(NUM_CH-1-ch) +: 8]];
      end
    end
    st2_meta.alpha <= alpha_sum[9:2];
    st2_meta.x     <= st1_x;
    st2_meta.y     <= st1_y;
  end

  // Stage 3 loads the search pipeline with the channel sums; each later stage
  // settles one bit of the output code, most significant first.
  logic       srch_valid [SEARCH_STEPS+1];
  gsum_t      srch_sum   [SEARCH_STEPS+1][NUM_CH];
  logic [7:0] srch_code  [SEARCH_STEPS+1][NUM_CH];
  meta_t      srch_meta  [SEARCH_STEPS+1];

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      srch_sum[0][ch]  <= gsum_t'(st2_t[0][ch]) + gsum_t'(st2_t[1][ch])
                        + gsum_t'(st2_t[2][ch]) + gsum_t'(st2_t[3][ch]);
      srch_code[0][ch] <= '0;
    end
    srch_meta[0] <= st2_meta;
    for (int k = 0; k < SEARCH_STEPS; k++) begin
      srch_meta[k+1] <= srch_meta[k];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        srch_sum[k+1][ch]  <= srch_sum[k][ch];
        srch_code[k+1][ch] <= search_step(srch_code[k][ch], srch_sum[k][ch], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      for (int k = 0; k <= SEARCH_STEPS; k++) begin
        srch_valid[k] <= 1'b0;
      end
    end else begin
      st1_valid     <= mem_re;
      st2_valid     <= st1_valid;
      srch_valid[0] <= st2_valid;
      for (int k = 0; k < SEARCH_STEPS; k++) begin
        srch_valid[k+1] <= srch_valid[k];
      end
    end
  end

  // Result queue. The outstanding count reserves a slot for every accepted
  // pixel that will produce a word, so the free-running pipeline never overflows.
  result_t            fifo_mem [RESULT_FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]   fifo_count;
  logic [CNT_W-1:0]   outstanding;
  logic               push;
  logic               pop;
  result_t            push_word;

  assign push = srch_valid[SEARCH_STEPS];
  assign pop  = result_valid && !result_stall;

  always_comb begin
    push_word.pixel = {srch_meta[SEARCH_STEPS].alpha, srch_code[SEARCH_STEPS][0],
                       srch_code[SEARCH_STEPS][1], srch_code[SEARCH_STEPS][2]};
    push_word.x     = srch_meta[SEARCH_STEPS].x;
    push_word.y     = srch_meta[SEARCH_STEPS].y;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fifo_count  <= '0;
      outstanding <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      fifo_count  <= fifo_count + CNT_W'(push) - CNT_W'(pop);
      outstanding <= outstanding + CNT_W'(accept && produce) - CNT_W'(pop);
    end
  end

  assign pixel_stall  = (outstanding == CNT_W'(RESULT_FIFO_DEPTH));
  assign result_valid = (fifo_count != '0);
  assign out_pixel    = fifo_mem[rd_ptr].pixel;
  assign out_x        = fifo_mem[rd_ptr].x;
  assign out_y        = fifo_mem[rd_ptr].y;

  `ASSERT_ALWAYS(a_queue_within_reserve, clk, rst, fifo_count <= outstanding, "queue holds more words than reserved")
  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, fifo_count < CNT_W'(RESULT_FIFO_DEPTH) || pop, "push into a full result queue")
  `ASSERT_ALWAYS(a_column_in_row, clk, rst, col_cnt <= last_col && last_col[0], "column counter beyond the row end")
  `ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_write_en, col_cnt == '0 && row_cnt == '0, "width write did not restart the image")

endmodule

// File: test/tb_gamma_correct_mipmap_downsampler.sv
// Self-checking testbench for the gamma-correct 2x2 mipmap downsampler.
// Holds its own linear-light blend predictor; depends only on gcmd_pkg and the RTL.
module tb_gamma_correct_mipmap_downsampler;
  timeunit 1ns;
  timeprecision 1ps;

  // The block hands a result over through its pipeline and result queue after the
  // pixel word that closes its 2x2 block, so these pauses cover that with margin.
  localparam int DRAIN_CYCLES   = 20;
  localparam int END_CYCLES     = 40;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LINE_DEPTH     = 2048;
  localparam int ROW_LIMIT      = 2048;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [gcmd_pkg::CFG_W-1:0] cfg_write_data;
  logic pixel_valid;
  logic pixel_stall;
  logic [gcmd_pkg::PIX_W-1:0] in_pixel;
  logic start_image;
  logic result_valid;
  logic result_stall;
  logic [gcmd_pkg::PIX_W-1:0] out_pixel;
  logic [gcmd_pkg::COORD_W-1:0] out_x;
  logic [gcmd_pkg::COORD_W-1:0] out_y;

  // Shared knobs between the stimulus and the result taker.
  logic steady;        // no idling on either side while set
  logic hold_request;  // asks the taker for one long stall

  always #5 clk = ~clk;

  gamma_correct_mipmap_downsampler dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .in_pixel(in_pixel),
    .start_image(start_image),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_pixel(out_pixel),
    .out_x(out_x),
    .out_y(out_y)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the line store, the previous pixel of the row,
  // the raster position and the width register, plus the linear-light table.
  // ---------------------------------------------------------------------------
  logic [24:0] lin_tab [256];
  logic [31:0] line_copy [LINE_DEPTH];
  logic [31:0] left_px;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [gcmd_pkg::CFG_W-1:0] width_reg;

  // Blended pixels that the block still owes, oldest first.
  gcmd_pkg::result_t pending_blends [$];
  int fail_count = 0;
  int quiet_cycles = 0;

  // True when t - 1/2 <= 2^24 * (code/255)^2.2. Both sides are raised to the
  // fifth power so the comparison stays in integers:
  // (2t-1)^5 * 255^11 <= 2^125 * code^11.
  function automatic logic fits_below(input int unsigned code, input int unsigned t);
    logic [255:0] lhs;
    logic [255:0] rhs;
    if (t == 0) return 1'b1;
    lhs = 256'd1;
    rhs = 256'd1 << 125;
    for (int i = 0; i < 5; i++) lhs = lhs * 256'(2 * t - 1);
    for (int i = 0; i < 11; i++) begin
      lhs = lhs * 256'd255;
      rhs = rhs * 256'(code);
    end
    return lhs <= rhs;
  endfunction

  // Clears the predictor as reset does and builds the table. Each entry starts
  // from a floating-point estimate and is nudged to the exact round-half-up value.
  task automatic reset_model();
    int unsigned t;
    for (int c = 0; c < 256; c++) begin
      t = $rtoi($pow(real'(c) / 255.0, 2.2) * 16777216.0 + 0.5);
      while (t > 0 && !fits_below(c, t)) t--;
      while (t < (1 << 24) && fits_below(c, t + 1)) t++;
      lin_tab[c] = t[24:0];
    end
    foreach (line_copy[i]) line_copy[i] = '0;
    left_px = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = gcmd_pkg::SOURCE_WIDTH_RESET;
  endtask

  // Width in use: forced even, at least 2, at most the line store depth.
  function automatic int unsigned row_width();
    int unsigned w;
    w = width_reg & 12'hFFE;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (w < 2) w = 2;
    return w;
  endfunction

  // Greatest code whose table entry, four times over, still fits under the sum
  // of the four entries: the mean in linear light, mapped back to a code.
  function automatic logic [7:0] linear_mean(input logic [7:0] p, input logic [7:0] q,
                                             input logic [7:0] r, input logic [7:0] s);
    logic [26:0] total;
    logic [7:0] code;
    total = 27'(lin_tab[p]) + 27'(lin_tab[q]) + 27'(lin_tab[r]) + 27'(lin_tab[s]);
    code = 8'd0;
    for (int k = 1; k < 256; k++) begin
      if ({lin_tab[k], 2'b00} <= total) code = 8'(k);
    end
    return code;
  endfunction

  // Advances the predictor by one accepted pixel word. Returns 1 and the blended
  // pixel when the word closes a 2x2 block (odd row, odd column).
  function automatic bit downsample_word(input logic [31:0] px, input logic restart,
                                         output gcmd_pkg::result_t blend);
    int unsigned w;
    int unsigned col;
    int unsigned row;
    logic [31:0] above_l;
    logic [31:0] above_r;
    logic [9:0] alpha_sum;
    bit made;
    w = row_width();
    made = 1'b0;
    blend = '0;
    if (restart) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    if (col >= w) col = w - 1;
    if (!row[0]) begin
      line_copy[col] = px;
    end else if (col[0]) begin
      above_l = line_copy[col - 1];
      above_r = line_copy[col];
      alpha_sum = 10'(above_l[31:24]) + 10'(above_r[31:24]) + 10'(left_px[31:24])
                + 10'(px[31:24]);
      blend.pixel = {alpha_sum[9:2],
                     linear_mean(above_l[23:16], above_r[23:16], left_px[23:16], px[23:16]),
                     linear_mean(above_l[15:8], above_r[15:8], left_px[15:8], px[15:8]),
                     linear_mean(above_l[7:0], above_r[7:0], left_px[7:0], px[7:0])};
      blend.x = 10'(col >> 1);
      blend.y = 10'(row >> 1);
      made = 1'b1;
    end
    left_px = px;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= ROW_LIMIT) row = 0;
    end
    col_pos = col;
    row_pos = row;
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed words. The block width is 2 here, so every four words form one
  // 2x2 block. Expected pixels are typed in only where they are obvious: all
  // zero, all ones, four equal pixels, and an alpha mean that truncates to zero.
  // The rest comes from the predictor. The last seven words restart the image
  // twice, the second time on the word that would have closed a block on an
  // odd row, and then finish one more block from the new start.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] pixel;
    logic        restart;
    logic        typed;
    logic [31:0] want_pixel;
    logic [9:0]  want_x;
    logic [9:0]  want_y;
  } directed_word_t;

  directed_word_t directed_words [27] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 10'd0, 10'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 10'd0, 10'd1},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678, 10'd0, 10'd2},
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 10'd0, 10'd3},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFF00_FF00, 1'b1, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h00FF_00FF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h8080_8080, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h7F7F_7F7F, 1'b1, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h00FF_FF00, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'h0000_FFFF, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0},
    '{32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 10'd0, 10'd0}
  };

  // Random pixel, biased toward the extremes of each channel and toward four
  // equal bytes so that the search lands on table boundaries often.
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom();
    case ($urandom_range(7))
      0: px = 32'h0000_0000;
      1: px = 32'hFFFF_FFFF;
      2: for (int k = 0; k < 4; k++) px[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      3: px = {4{px[7:0]}};
      default: ;
    endcase
    return px;
  endfunction

  // Offers one pixel word, idling first at random unless a steady stretch is
  // on. The stall is looked at on the falling edge, where it is settled, and
  // the word is taken at the rising edge that follows. Returns at that edge.
  task automatic send_word(input logic [31:0] px, input logic restart, input bit typed,
                           input gcmd_pkg::result_t typed_blend);
    bit taken;
    gcmd_pkg::result_t blend;
    while (!steady && $urandom_range(99) < 36) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    in_pixel <= px;
    start_image <= restart;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !pixel_stall;
      @(posedge clk);
    end
    if (downsample_word(px, restart, blend)) pending_blends.push_back(typed ? typed_blend : blend);
  endtask

  // A run of random pixel words. The first word may restart the image; after
  // that a restart comes now and then when restart_odds is nonzero, which
  // breaks rows and leaves odd trailing rows behind.
  task automatic run_pixels(input int count, input int restart_odds);
    logic restart;
    for (int n = 0; n < count; n++) begin
      restart = (n == 0 && $urandom_range(1) == 1)
             || (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
      send_word(random_pixel(), restart, 1'b0, '0);
    end
    pixel_valid <= 1'b0;
  endtask

  // Writes the width only once the block has nothing left to hand over, and a
  // few cycles later still, since words of an even row leave no result behind.
  task automatic write_width(input logic [gcmd_pkg::CFG_W-1:0] value);
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    width_reg = value;
    col_pos = 0;
    row_pos = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result taker: stalls at random, or not at all during a steady stretch, and
  // once holds off for a long count so the result queue fills and the block
  // has to stall its pixel input.
  // ---------------------------------------------------------------------------
  initial begin : result_taker
    int held;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        result_stall <= 1'b1;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end
      result_stall <= !steady && ($urandom_range(99) < 36);
    end
  end

  // Result check and watchdog. Both handshakes are looked at on the falling
  // edge; a word seen there is taken at the next rising edge.
  gcmd_pkg::result_t oldest;

  always @(negedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_blends.size() == 0) begin
          $error("result with none expected: out_pixel %h out_x %0d out_y %0d",
                 out_pixel, out_x, out_y);
          fail_count++;
        end else begin
          oldest = pending_blends.pop_front();
          if (out_pixel !== oldest.pixel) begin
            $error("out_pixel expected %h actual %h", oldest.pixel, out_pixel);
            fail_count++;
          end
          if (out_x !== oldest.x) begin
            $error("out_x expected %0d actual %0d", oldest.x, out_x);
            fail_count++;
          end
          if (out_y !== oldest.y) begin
            $error("out_y expected %0d actual %0d", oldest.y, out_y);
            fail_count++;
          end
        end
      end
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("[gamma_correct_mipmap_downsampler] ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Phases run through several widths: the reset value, the minimum,
  // odd values, values below two, the all-ones value that saturates to the
  // line store depth, and the exact depth.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    gcmd_pkg::result_t typed_blend;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    pixel_valid = 1'b0;
    in_pixel = '0;
    start_image = 1'b0;
    steady = 1'b0;
    hold_request = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset width of 16, no register write yet.
    run_pixels(100, 40);

    // Directed words at the smallest width.
    write_width(12'd2);
    foreach (directed_words[i]) begin
      typed_blend.pixel = directed_words[i].want_pixel;
      typed_blend.x = directed_words[i].want_x;
      typed_blend.y = directed_words[i].want_y;
      send_word(directed_words[i].pixel, directed_words[i].restart,
                directed_words[i].typed, typed_blend);
    end
    pixel_valid <= 1'b0;

    write_width(12'd6);
    run_pixels(60, 30);
    // Odd width: the low bit is dropped.
    write_width(12'd7);
    run_pixels(60, 30);
    // Widths below two behave as two.
    write_width(12'd0);
    run_pixels(40, 20);
    write_width(12'd1);
    run_pixels(40, 20);

    // Long hold on the result side while pixels keep coming at width 2, so
    // results pile up and the block stalls its input.
    write_width(12'd2);
    hold_request <= 1'b1;
    run_pixels(160, 50);

    // A long stretch with no idling on either side.
    write_width(12'd10);
    steady <= 1'b1;
    run_pixels(100, 25);

    // All ones saturates to the full line; part of the first row only.
    write_width(12'hFFF);
    run_pixels(40, 0);
    steady <= 1'b0;

    write_width(12'd2048);
    run_pixels(30, 0);

    write_width(12'd16);
    run_pixels(50, 40);

    while (pending_blends.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[gamma_correct_mipmap_downsampler] OK");
    end else begin
      $display("[gamma_correct_mipmap_downsampler] ERROR");
    end
    $finish;
  end

endmodule
